// ----- design/assert_macros.svh -----
// assertion macros shared by the event log ring modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ELMR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ELMR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELMR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/elmr_pkg.sv -----
// types, widths and defaults of the event log ring
package elmr_pkg;

    localparam int STATUS_POINTS_DEF = 256;
    localparam int EVENT_DEPTH_DEF   = 256;
    localparam int READERS_DEF       = 4;
    localparam int BATCH_MAX_DEF     = 16;
    localparam int RESULT_LIMIT      = 16;
    localparam int CMD_FIFO_DEPTH    = 2;
    localparam int RES_FIFO_DEPTH    = 4;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 16;
    localparam int VAL_W     = 8;
    localparam int TS_W      = 56;
    localparam int RD_IN_W   = 2;
    localparam int CNT_W     = 5;
    localparam int IMG_IDX_W = 12;
    // wide enough for base address plus the largest image
    localparam int WIN_W     = 18;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_CHECK  = 2'd1,
        OP_DRAIN  = 2'd2,
        OP_STATUS = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_RECORD,
        CMD_CHECK,
        CMD_DRAIN,
        CMD_STATUS,
        CMD_REJECT
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        t_op                operation;
        logic [ADDR_W-1:0]  info_address;
        logic [VAL_W-1:0]   event_value;
        logic [TS_W-1:0]    event_timestamp;
        logic [RD_IN_W-1:0] reader_index;
        logic [CNT_W-1:0]   point_count;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic               has_events;
        logic [ADDR_W-1:0]  item_address;
        logic [VAL_W-1:0]   item_value;
        logic [TS_W-1:0]    item_timestamp;
        logic [CNT_W-1:0]   batch_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind            kind;
        logic                 in_window;
        logic [IMG_IDX_W-1:0] img_idx;
        logic [ADDR_W-1:0]    addr;
        logic [VAL_W-1:0]     value;
        logic [TS_W-1:0]      ts;
        logic [RD_IN_W-1:0]   reader;
        logic [CNT_W-1:0]     count;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

// ----- design/event_log_multi_reader_ring_top.sv -----
// top level of the multi-reader event log ring
// requests enter through a queue-style port: present i_item and raise push;
// the transaction completes on a clock edge with push high and full low
// results leave the same way: while empty is low o_result holds the oldest
// result, and pop high at a clock edge takes it
// one configuration register, status_base_address, is written through
// i_cfg_valid / o_cfg_ready / i_cfg_data; ready is always high, and writes
// belong to idle periods only
// a front end classifies each request (window and reader checks) and hands
// it through a two-entry command queue to a back end that owns the ring,
// the status image and the reader pointers; results go into a four-entry
// output queue
// timing: record, check and rejected requests flow one per cycle while the
// back end is idle and the output queue has room; drain reads that find events
// and status reads pass through a read state before each result, set by the
// registered memory read in the back end, and hold off requests until done
// reset: full stays high while the back end clears the status image one
// entry a cycle; pointers reset to zero at once
// a stalled receiver fills the output queue, the back end then waits, the
// command queue fills and full rises; nothing is lost or repeated
module event_log_multi_reader_ring_top #(
    parameter int STATUS_POINTS = elmr_pkg::STATUS_POINTS_DEF,
    parameter int EVENT_DEPTH   = elmr_pkg::EVENT_DEPTH_DEF,
    parameter int READERS       = elmr_pkg::READERS_DEF,
    parameter int BATCH_MAX     = elmr_pkg::BATCH_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request side
    input  logic                        push,
    output logic                        full,
    input  elmr_pkg::t_in_item          i_item,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output elmr_pkg::t_out_item         o_result,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [elmr_pkg::ADDR_W-1:0] i_cfg_data
);

    localparam int CMD_W = $bits(elmr_pkg::t_cmd);
    localparam int RES_W = $bits(elmr_pkg::t_out_item);

    elmr_pkg::t_cmd         front_cmd;
    logic [CMD_W-1:0]       cmd_q_data;
    logic                   cmd_q_full;
    logic                   cmd_q_empty;
    logic                   cmd_pop;
    elmr_pkg::t_out_item    back_res;
    logic                   res_push;
    logic                   res_q_full;
    logic [RES_W-1:0]       res_q_data;
    elmr_pkg::t_back_status back_status;

    // no request is taken while the status image is being cleared
    assign full     = cmd_q_full || back_status.clearing;
    assign o_result = elmr_pkg::t_out_item'(res_q_data);

    elmr_front #(
        .STATUS_POINTS (STATUS_POINTS),
        .READERS       (READERS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .o_cmd       (front_cmd)
    );

    // command queue between classification and execution
    elmr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (elmr_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (front_cmd),
        .o_full  (cmd_q_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_q_data),
        .o_empty (cmd_q_empty)
    );

    elmr_back #(
        .STATUS_POINTS (STATUS_POINTS),
        .EVENT_DEPTH   (EVENT_DEPTH),
        .READERS       (READERS),
        .BATCH_MAX     (BATCH_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (elmr_pkg::t_cmd'(cmd_q_data)),
        .i_cmd_empty (cmd_q_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_q_full),
        .o_status    (back_status)
    );

    // output queue parts the back end from the receiver
    elmr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (elmr_pkg::RES_FIFO_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_q_full),
        .i_pop   (pop),
        .o_data  (res_q_data),
        .o_empty (empty)
    );

endmodule

// ----- design/elmr_fifo.sv -----
// small first-in first-out queue of packed words
`include "assert_macros.svh"

module elmr_fifo #(
    parameter int WIDTH = $bits(elmr_pkg::t_out_item),
    parameter int DEPTH = elmr_pkg::RES_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ELMR_ASSERT(a_count_bound, r_count <= CW'(DEPTH), "fifo count beyond depth")
    `ELMR_ASSERT_NEXT(a_pop_drains, i_pop && !o_empty && !i_push, r_count == $past(r_count) - 1'b1, "fifo pop lost")

endmodule

// ----- design/elmr_front.sv -----
// front end: configuration register and request classification
module elmr_front #(
    parameter int STATUS_POINTS = elmr_pkg::STATUS_POINTS_DEF,
    parameter int READERS       = elmr_pkg::READERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [elmr_pkg::ADDR_W-1:0] i_cfg_data,
    input  elmr_pkg::t_in_item          i_item,
    output elmr_pkg::t_cmd              o_cmd
);

    localparam int WIN_W = elmr_pkg::WIN_W;

    logic [elmr_pkg::ADDR_W-1:0] r_base;
    logic [WIN_W-1:0]            base_w;
    logic [WIN_W-1:0]            addr_w;
    logic [WIN_W-1:0]            lim_w;
    logic [WIN_W-1:0]            offset_w;
    logic                        in_window;
    logic                        rd_ok;
    logic                        stat_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= elmr_pkg::ADDR_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base <= i_cfg_data;
        end
    end

    always_comb begin
        base_w    = WIN_W'(r_base);
        addr_w    = WIN_W'(i_item.info_address);
        lim_w     = base_w + WIN_W'(STATUS_POINTS);
        offset_w  = addr_w - base_w;
        in_window = (addr_w >= base_w) && (addr_w < lim_w);
        rd_ok     = (32'(i_item.reader_index) < READERS);
        stat_ok   = (i_item.point_count != '0)
                 && (i_item.point_count <= elmr_pkg::CNT_W'(elmr_pkg::RESULT_LIMIT))
                 && (addr_w >= base_w)
                 && (addr_w + WIN_W'(i_item.point_count) <= lim_w);
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.in_window = in_window;
        o_cmd.img_idx   = offset_w[elmr_pkg::IMG_IDX_W-1:0];
        o_cmd.addr      = i_item.info_address;
        o_cmd.value     = i_item.event_value;
        o_cmd.ts        = i_item.event_timestamp;
        o_cmd.reader    = i_item.reader_index;
        o_cmd.count     = i_item.point_count;
        case (i_item.operation)
            elmr_pkg::OP_RECORD: o_cmd.kind = elmr_pkg::CMD_RECORD;
            elmr_pkg::OP_CHECK:  o_cmd.kind = rd_ok ? elmr_pkg::CMD_CHECK : elmr_pkg::CMD_REJECT;
            elmr_pkg::OP_DRAIN:  o_cmd.kind = rd_ok ? elmr_pkg::CMD_DRAIN : elmr_pkg::CMD_REJECT;
            elmr_pkg::OP_STATUS: o_cmd.kind = stat_ok ? elmr_pkg::CMD_STATUS
                                                      : elmr_pkg::CMD_REJECT;
            default:             o_cmd.kind = elmr_pkg::CMD_REJECT;
        endcase
    end

endmodule

// ----- design/elmr_back.sv -----
// back end: event ring, status image, reader pointers and result sequencer
`include "assert_macros.svh"

module elmr_back #(
    parameter int STATUS_POINTS = elmr_pkg::STATUS_POINTS_DEF,
    parameter int EVENT_DEPTH   = elmr_pkg::EVENT_DEPTH_DEF,
    parameter int READERS       = elmr_pkg::READERS_DEF,
    parameter int BATCH_MAX     = elmr_pkg::BATCH_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  elmr_pkg::t_cmd         i_cmd,
    input  logic                   i_cmd_empty,
    output logic                   o_cmd_pop,
    output elmr_pkg::t_out_item    o_res,
    output logic                   o_res_push,
    input  logic                   i_res_full,
    output elmr_pkg::t_back_status o_status
);

    localparam int PTR_W = $clog2(EVENT_DEPTH);
    localparam int DW    = PTR_W + 1;
    localparam int IMG_W = (STATUS_POINTS > 1) ? $clog2(STATUS_POINTS) : 1;
    localparam int RD_W  = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int LIMIT = (BATCH_MAX < elmr_pkg::RESULT_LIMIT) ? BATCH_MAX
                                                                : elmr_pkg::RESULT_LIMIT;
    localparam int CNT_W = elmr_pkg::CNT_W;
    localparam int VAL_W = elmr_pkg::VAL_W;

    typedef struct packed {
        logic [elmr_pkg::ADDR_W-1:0] addr;
        logic [VAL_W-1:0]            value;
        logic [elmr_pkg::TS_W-1:0]   ts;
    } t_ev_slot;

    function automatic logic [PTR_W-1:0] f_ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(EVENT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // storage
    t_ev_slot         r_event_mem [EVENT_DEPTH];
    logic [VAL_W-1:0] r_img_mem   [STATUS_POINTS];
    t_ev_slot         r_ev_rdata;
    logic [VAL_W-1:0] r_img_rdata;

    // control and pointers
    elmr_pkg::t_back_state       r_state, n_state;
    logic [PTR_W-1:0]            r_wp, n_wp;
    logic [PTR_W-1:0]            r_rp [READERS];
    logic [PTR_W-1:0]            n_rp [READERS];
    logic [IMG_W-1:0]            r_clr_idx, n_clr_idx;

    // batch in progress
    logic [PTR_W-1:0]            r_ev_ptr, n_ev_ptr;
    logic [IMG_W-1:0]            r_img_ptr, n_img_ptr;
    logic [RD_W-1:0]             r_rd, n_rd;
    logic [CNT_W-1:0]            r_total, n_total;
    logic [CNT_W-1:0]            r_k, n_k;
    logic [elmr_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic                        r_is_drain, n_is_drain;

    logic [RD_W-1:0]             cmd_rd;
    logic [PTR_W-1:0]            cmd_rp;
    logic [PTR_W-1:0]            wp_next;
    logic [PTR_W-1:0]            span;
    logic [CNT_W-1:0]            n_take;
    logic                        has_ev;
    logic                        emit_last;
    logic                        rec_take;

    logic                        ev_we;
    logic                        img_we;
    logic [IMG_W-1:0]            img_wa;
    logic [VAL_W-1:0]            img_wd;

    assign o_status.clearing = (r_state == elmr_pkg::BK_CLEAR);
    assign rec_take          = o_cmd_pop && (i_cmd.kind == elmr_pkg::CMD_RECORD);

    always_comb begin
        cmd_rd    = RD_W'(i_cmd.reader);
        cmd_rp    = r_rp[cmd_rd];
        wp_next   = f_ring_next(r_wp);
        has_ev    = (cmd_rp != r_wp);
        if (r_wp >= cmd_rp) begin
            span = r_wp - cmd_rp;
        end else begin
            span = PTR_W'(DW'(r_wp) + DW'(EVENT_DEPTH) - DW'(cmd_rp));
        end
        n_take    = (32'(span) > LIMIT) ? CNT_W'(LIMIT) : CNT_W'(span);
        emit_last = (r_k + 1'b1 == r_total);
    end

    // outputs: queue handshakes, result payload, memory writes
    always_comb begin
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        ev_we      = 1'b0;
        img_we     = 1'b0;
        img_wa     = i_cmd.img_idx[IMG_W-1:0];
        img_wd     = i_cmd.value;
        case (r_state)
            elmr_pkg::BK_CLEAR: begin
                img_we = 1'b1;
                img_wa = r_clr_idx;
                img_wd = '0;
            end
            elmr_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    case (i_cmd.kind)
                        elmr_pkg::CMD_RECORD: begin
                            if (!i_res_full) begin
                                o_cmd_pop      = 1'b1;
                                o_res_push     = 1'b1;
                                o_res.accepted = 1'b1;
                                o_res.last     = 1'b1;
                                ev_we          = 1'b1;
                                img_we         = i_cmd.in_window;
                            end
                        end
                        elmr_pkg::CMD_CHECK: begin
                            if (!i_res_full) begin
                                o_cmd_pop        = 1'b1;
                                o_res_push       = 1'b1;
                                o_res.accepted   = has_ev;
                                o_res.has_events = has_ev;
                                o_res.last       = 1'b1;
                            end
                        end
                        elmr_pkg::CMD_DRAIN: begin
                            if (has_ev) begin
                                o_cmd_pop = 1'b1;
                            end else if (!i_res_full) begin
                                o_cmd_pop  = 1'b1;
                                o_res_push = 1'b1;
                                o_res.last = 1'b1;
                            end
                        end
                        elmr_pkg::CMD_STATUS: begin
                            o_cmd_pop = 1'b1;
                        end
                        default: begin
                            // rejected request: all zero but last
                            if (!i_res_full) begin
                                o_cmd_pop  = 1'b1;
                                o_res_push = 1'b1;
                                o_res.last = 1'b1;
                            end
                        end
                    endcase
                end
            end
            elmr_pkg::BK_EMIT: begin
                if (!i_res_full) begin
                    o_res_push        = 1'b1;
                    o_res.accepted    = 1'b1;
                    o_res.batch_count = r_total;
                    o_res.last        = emit_last;
                    if (r_is_drain) begin
                        o_res.item_address   = r_ev_rdata.addr;
                        o_res.item_value     = r_ev_rdata.value;
                        o_res.item_timestamp = r_ev_rdata.ts;
                    end else begin
                        o_res.item_address = r_addr;
                        o_res.item_value   = r_img_rdata;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_clr_idx  = r_clr_idx;
        n_ev_ptr   = r_ev_ptr;
        n_img_ptr  = r_img_ptr;
        n_rd       = r_rd;
        n_total    = r_total;
        n_k        = r_k;
        n_addr     = r_addr;
        n_is_drain = r_is_drain;
        case (r_state)
            elmr_pkg::BK_CLEAR: begin
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IMG_W'(STATUS_POINTS - 1)) begin
                    n_state = elmr_pkg::BK_IDLE;
                end
            end
            elmr_pkg::BK_IDLE: begin
                if (o_cmd_pop) begin
                    case (i_cmd.kind)
                        elmr_pkg::CMD_RECORD: begin
                            n_wp = wp_next;
                            // readers caught by the writer lose their oldest event
                            for (int i = 0; i < READERS; i++) begin
                                if (r_rp[i] == wp_next) begin
                                    n_rp[i] = f_ring_next(r_rp[i]);
                                end
                            end
                        end
                        elmr_pkg::CMD_DRAIN: begin
                            if (has_ev) begin
                                n_ev_ptr   = cmd_rp;
                                n_rd       = cmd_rd;
                                n_total    = n_take;
                                n_k        = '0;
                                n_is_drain = 1'b1;
                                n_state    = elmr_pkg::BK_READ;
                            end
                        end
                        elmr_pkg::CMD_STATUS: begin
                            n_img_ptr  = i_cmd.img_idx[IMG_W-1:0];
                            n_addr     = i_cmd.addr;
                            n_total    = i_cmd.count;
                            n_k        = '0;
                            n_is_drain = 1'b0;
                            n_state    = elmr_pkg::BK_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            elmr_pkg::BK_READ: begin
                n_state = elmr_pkg::BK_EMIT;
            end
            elmr_pkg::BK_EMIT: begin
                if (o_res_push) begin
                    n_k       = r_k + 1'b1;
                    n_ev_ptr  = f_ring_next(r_ev_ptr);
                    n_img_ptr = r_img_ptr + 1'b1;
                    n_addr    = r_addr + 1'b1;
                    if (emit_last) begin
                        if (r_is_drain) begin
                            n_rp[r_rd] = f_ring_next(r_ev_ptr);
                        end
                        n_state = elmr_pkg::BK_IDLE;
                    end else begin
                        n_state = elmr_pkg::BK_READ;
                    end
                end
            end
            default: begin
                n_state = elmr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= elmr_pkg::BK_CLEAR;
            r_wp      <= '0;
            r_clr_idx <= '0;
            for (int i = 0; i < READERS; i++) begin
                r_rp[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_clr_idx <= n_clr_idx;
            r_rp      <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_ptr   <= n_ev_ptr;
        r_img_ptr  <= n_img_ptr;
        r_rd       <= n_rd;
        r_total    <= n_total;
        r_k        <= n_k;
        r_addr     <= n_addr;
        r_is_drain <= n_is_drain;
    end

    always_ff @(posedge i_clk) begin
        if (ev_we) begin
            r_event_mem[r_wp] <= '{addr: i_cmd.addr, value: i_cmd.value, ts: i_cmd.ts};
        end
        r_ev_rdata <= r_event_mem[r_ev_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            r_img_mem[img_wa] <= img_wd;
        end
        r_img_rdata <= r_img_mem[r_img_ptr];
    end

    `ELMR_ASSERT_IMPLIES(a_emit_k, r_state == elmr_pkg::BK_EMIT, r_k < r_total, "batch overrun")
    `ELMR_ASSERT_IMPLIES(a_push_room, o_res_push, !i_res_full, "result pushed into full queue")
    `ELMR_ASSERT_IMPLIES(a_clear_no_pop, o_status.clearing, !o_cmd_pop, "request taken during clear")
    `ELMR_ASSERT_NEXT(a_record_moves_wp, rec_take, r_wp != $past(r_wp), "write pointer stuck")

endmodule
